### rtl/sobel_et_pkg.sv
// shared types and constants of the sobel edge threshold block
package sobel_et_pkg;

    localparam int PIX_W         = 8;
    localparam int CFG_W_W       = 11;
    localparam int CFG_H_W       = 13;
    localparam int THR_W         = 11;
    localparam int CFG_DATA_W    = 13;
    localparam int CFG_IDX_W     = 2;
    localparam int ROW_W         = 13;
    localparam int SUM_W         = 10;
    localparam int GRAD_W        = 11;
    localparam int MAX_HEIGHT    = 4096;
    localparam int DEF_MAX_WIDTH = 1024;

    localparam logic [CFG_W_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_H_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [THR_W-1:0]   THR_RESET    = 11'd20;

    localparam logic [PIX_W-1:0] EDGE_ON  = 8'd255;
    localparam logic [PIX_W-1:0] EDGE_OFF = 8'd0;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THRESHOLD = 2'd2;

    typedef enum logic
    {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } opcode_t;

    typedef struct packed
    {
        opcode_t          opcode;
        logic [PIX_W-1:0] pixel;
    } in_item_t;

    typedef struct packed
    {
        logic [PIX_W-1:0] edge_value;
        logic             frame_last;
    } out_item_t;

    // [row][col], col 0 is the leftmost column
    typedef logic [2:0][2:0][PIX_W-1:0] kernel_t;

endpackage

### rtl/sobel_edge_threshold_core.sv
// Streaming 3x3 sobel edge detector with binary threshold. Grey pixels of a frame enter in
// raster order, one request per clock unless stalled; each pixel request returns at most one
// result, 0 or 255, and results trail their pixels by one row plus one pixel, so the first
// row and the first pixel of the second row give none. After the frame's last pixel, send
// flush requests: each returns one pending result and the last one carries frame_last. A
// pixel request sent while results are pending, or a flush with nothing pending, is taken and
// dropped. The single line store ram reads the next column ahead, and the first flush of a
// one-row frame is held for a second step. A result is registered and appears in the cycle
// after its request is taken. Neighbors outside the image count as zero. Width is clamped to
// 1..MAX_WIDTH, height to 1..4096; write the registers only while no request is held.
module sobel_edge_threshold_core #(
    parameter int MAX_WIDTH = sobel_et_pkg::DEF_MAX_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 pix_valid,
    output logic                                 pix_stall,
    input  sobel_et_pkg::in_item_t               pix_data,
    output logic                                 res_valid,
    input  logic                                 res_stall,
    output sobel_et_pkg::out_item_t              res_data,
    input  logic                                 cfg_we,
    input  logic [sobel_et_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sobel_et_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sobel_et_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = (CW + 1 > CFG_W_W) ? CW + 1 : CFG_W_W;
    localparam int PW = $clog2(MAX_WIDTH + 2);
    localparam int SW = 2 * PIX_W;

    logic [CFG_W_W-1:0] width_reg;
    logic [CFG_H_W-1:0] height_reg;
    logic [THR_W-1:0]   thr_reg;

    logic      in_valid_reg, in_valid_next;
    in_item_t  in_item_reg;
    logic      res_valid_reg, res_valid_next;
    out_item_t res_item_reg, res_item_next;

    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [PW-1:0]    pend_reg, pend_next, pend_dec;
    logic             step2_reg, step2_next;
    kernel_t          win_reg, win_next, win_adv, kern;

    logic           byp_reg;
    logic [SW-1:0]  byp_data_reg;
    logic [SW-1:0]  ram_q, store_word, ram_wdata;
    logic           ram_we;

    logic [EW-1:0]      eff_w;
    logic [CFG_H_W-1:0] eff_h;
    logic [PIX_W-1:0]   up_raw, lo_raw, top_px, mid_px, bot_px, edge_px;
    logic fire, is_pixel, do_adv, produce, emit, go_step2, consume, wrap, last_pixel;
    logic frame_end, take_in;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            thr_reg    <= THR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:    width_reg  <= cfg_data[CFG_W_W-1:0];
                CFG_IMAGE_HEIGHT:   height_reg <= cfg_data[CFG_H_W-1:0];
                CFG_EDGE_THRESHOLD: thr_reg    <= cfg_data[THR_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        priority if (width_reg == '0)
            eff_w = EW'(1);
        else if (EW'(width_reg) > EW'(MAX_WIDTH))
            eff_w = EW'(MAX_WIDTH);
        else
            eff_w = EW'(width_reg);

        priority if (height_reg == '0)
            eff_h = CFG_H_W'(1);
        else if (height_reg > CFG_H_W'(MAX_HEIGHT))
            eff_h = CFG_H_W'(MAX_HEIGHT);
        else
            eff_h = height_reg;
    end

    // line stores: upper row in the high byte, lower row in the low byte
    sobel_et_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (col_reg),
        .wdata (ram_wdata),
        .raddr (col_next),
        .rdata (ram_q)
    );

    assign store_word = byp_reg ? byp_data_reg : ram_q;
    assign up_raw     = store_word[SW-1:PIX_W];
    assign lo_raw     = store_word[PIX_W-1:0];

    // request control
    assign fire     = in_valid_reg && (!res_valid_reg || !res_stall);
    assign is_pixel = (in_item_reg.opcode == OP_PIXEL);
    assign do_adv   = fire && (is_pixel ? (pend_reg == '0) : (pend_reg != '0));
    assign produce  = (row_reg >= ROW_W'(2)) || ((row_reg == ROW_W'(1)) && (col_reg != '0));
    assign emit     = do_adv && (produce || (!is_pixel && step2_reg));
    // one-row frame: first flush position yields nothing, take a second position
    assign go_step2 = do_adv && !is_pixel && !produce && !step2_reg;
    assign consume  = fire && !go_step2;
    assign pix_stall = in_valid_reg && !consume;
    assign take_in  = pix_valid && !pix_stall;

    assign wrap       = (EW'(col_reg) + EW'(1)) >= eff_w;
    assign last_pixel = wrap &&
        (((ROW_W + 1)'(row_reg) + (ROW_W + 1)'(1)) >= (ROW_W + 1)'(eff_h));
    assign pend_dec   = pend_reg - PW'(1);
    assign frame_end  = emit && !is_pixel && (pend_dec == '0);

    assign ram_we    = do_adv && is_pixel;
    assign ram_wdata = {lo_raw, in_item_reg.pixel};

    // window shift and kernel
    always_comb
    begin
        top_px = (row_reg >= ROW_W'(2)) ? up_raw : '0;
        mid_px = (row_reg != '0) ? lo_raw : '0;
        bot_px = is_pixel ? in_item_reg.pixel : '0;
        win_adv = win_reg;
        kern    = win_reg;
        for (int i = 0; i < 3; i++)
        begin
            if (col_reg == '0)
            begin
                kern[i][0]    = win_reg[i][1];
                kern[i][1]    = win_reg[i][2];
                kern[i][2]    = '0;
                win_adv[i][0] = '0;
                win_adv[i][1] = '0;
            end
            else
            begin
                win_adv[i][0] = win_reg[i][1];
                win_adv[i][1] = win_reg[i][2];
            end
        end
        win_adv[0][2] = top_px;
        win_adv[1][2] = mid_px;
        win_adv[2][2] = bot_px;
        if (col_reg != '0)
        begin
            kern = win_adv;
        end
    end

    sobel_et_grad u_grad (
        .kern       (kern),
        .threshold  (thr_reg),
        .edge_value (edge_px)
    );

    // next state
    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        pend_next  = pend_reg;
        win_next   = win_reg;
        step2_next = step2_reg;

        if (fire)
        begin
            step2_next = go_step2;
        end
        if (do_adv)
        begin
            win_next = win_adv;
            if (wrap)
            begin
                col_next = '0;
                if (row_reg != '1)
                begin
                    row_next = row_reg + ROW_W'(1);
                end
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
        if (do_adv && is_pixel && last_pixel)
        begin
            pend_next = (row_reg == '0) ? PW'(eff_w) : PW'(eff_w) + PW'(1);
        end
        if (emit && !is_pixel)
        begin
            pend_next = pend_dec;
        end
        if (frame_end)
        begin
            col_next = '0;
            row_next = '0;
            win_next = '0;
        end

        in_valid_next = take_in ? 1'b1 : (consume ? 1'b0 : in_valid_reg);

        res_item_next = res_item_reg;
        if (emit)
        begin
            res_valid_next           = 1'b1;
            res_item_next.edge_value = produce ? edge_px : EDGE_OFF;
            res_item_next.frame_last = frame_end;
        end
        else
        begin
            res_valid_next = res_stall ? res_valid_reg : 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            pend_reg      <= '0;
            step2_reg     <= 1'b0;
            win_reg       <= '0;
            byp_reg       <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            pend_reg      <= pend_next;
            step2_reg     <= step2_next;
            win_reg       <= win_next;
            // write and read-ahead hit the same column
            byp_reg       <= ram_we && (col_reg == col_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_item_reg <= pix_data;
        end
        res_item_reg <= res_item_next;
        byp_data_reg <= ram_wdata;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_item_reg;

    a_step2_held: assert property (@(posedge clk) disable iff (!rst_n)
        step2_reg |-> (in_valid_reg && (pend_reg != '0)))
        else $error("second flush step without a held flush request");

    a_frame_reset: assert property (@(posedge clk) disable iff (!rst_n)
        frame_end |=> ((col_reg == '0) && (row_reg == '0) && (pend_reg == '0)))
        else $error("counters not cleared after frame end");

    a_bypass_write: assert property (@(posedge clk) disable iff (!rst_n)
        byp_reg |-> $past(ram_we))
        else $error("line store bypass without a write");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_item_reg.frame_last) |-> (pend_reg == '0))
        else $error("frame_last result while results still pending");

endmodule

### rtl/sobel_et_ram.sv
// generic single-port-write, registered-read ram
module sobel_et_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/sobel_et_grad.sv
// sobel gradient magnitude and threshold compare over one 3x3 kernel
module sobel_et_grad (
    input  sobel_et_pkg::kernel_t                  kern,
    input  logic [sobel_et_pkg::THR_W-1:0]         threshold,
    output logic [sobel_et_pkg::PIX_W-1:0]         edge_value
);
    import sobel_et_pkg::*;

    logic [SUM_W-1:0]  top_sum;
    logic [SUM_W-1:0]  bot_sum;
    logic [SUM_W-1:0]  lft_sum;
    logic [SUM_W-1:0]  rgt_sum;
    logic [SUM_W-1:0]  gy_abs;
    logic [SUM_W-1:0]  gx_abs;
    logic [GRAD_W-1:0] grad;

    // 1,2,1 weighting
    function automatic logic [SUM_W-1:0] weighted(
        input logic [PIX_W-1:0] a,
        input logic [PIX_W-1:0] b,
        input logic [PIX_W-1:0] c
    );
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + (SUM_W'(b) << 1) + SUM_W'(c);
        return s;
    endfunction

    always_comb
    begin
        top_sum = weighted(kern[0][0], kern[0][1], kern[0][2]);
        bot_sum = weighted(kern[2][0], kern[2][1], kern[2][2]);
        lft_sum = weighted(kern[0][0], kern[1][0], kern[2][0]);
        rgt_sum = weighted(kern[0][2], kern[1][2], kern[2][2]);
        gy_abs  = (top_sum >= bot_sum) ? top_sum - bot_sum : bot_sum - top_sum;
        gx_abs  = (lft_sum >= rgt_sum) ? lft_sum - rgt_sum : rgt_sum - lft_sum;
        grad    = GRAD_W'(gy_abs) + GRAD_W'(gx_abs);
        edge_value = (grad < threshold) ? EDGE_OFF : EDGE_ON;
    end

endmodule
